>>> design/cbpd_pkg.sv
// shared types, constants and helpers for the cascaded balance pd controller
package cbpd_pkg;

  localparam int SPEED_LIMIT_DEF  = 1000;
  localparam int MECH_ZERO_DEF    = 0;
  localparam int SPEED_DIVIDE_DEF = 4;

  localparam int GAIN_W = 16;
  localparam int DATA_W = 16;
  localparam int LIM_W  = 15;
  localparam int CFG_IDX_W = 3;

  // sum of two 16x17 products fits in 35 bits signed
  localparam int ACC_W = 35;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_KP  = 3'd0,
    REG_SPEED_KD  = 3'd1,
    REG_ANGLE_KP  = 3'd2,
    REG_ANGLE_KD  = 3'd3,
    REG_RATE_KP   = 3'd4,
    REG_RATE_KD   = 3'd5,
    REG_OUT_LIMIT = 3'd6,
    REG_FALL      = 3'd7
  } cfg_idx_t;

  // request to the serial pd unit and its answer
  typedef struct packed {
    logic                      start;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         kd;
    logic signed [DATA_W-1:0]  err;
    logic signed [DATA_W-1:0]  last;
  } pd_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [ACC_W-1:0]   result;
  } pd_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 35'sd32767) r = 16'sh7fff;
    else if (v < -35'sd32768) r = 16'sh8000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] clampv(input logic signed [ACC_W-1:0] v,
                                                    input logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

>>> design/cbpd_if.sv
// valid/ready channel interfaces for tick inputs and duty results
interface cbpd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cbpd_pkg::DATA_W-1:0]   tilt_angle;
  logic signed [cbpd_pkg::DATA_W-1:0]   encoder_delta;
  logic signed [cbpd_pkg::DATA_W-1:0]   gyro_rate;
  logic                                 rest_request;
  modport source (output valid, tilt_angle, encoder_delta, gyro_rate, rest_request,
                  input ready);
  modport sink (input valid, tilt_angle, encoder_delta, gyro_rate, rest_request,
                output ready);
endinterface

interface cbpd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [cbpd_pkg::LIM_W-1:0]           duty_magnitude;
  logic                                 direction;
  logic                                 fallen;
  modport source (output valid, duty_magnitude, direction, fallen, input ready);
  modport sink (input valid, duty_magnitude, direction, fallen, output ready);
endinterface

>>> design/cbpd_pd_serial.sv
// bit-serial pd unit: kp*err + kd*(err-last), then divide by 256 toward zero
module cbpd_pd_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  cbpd_pkg::pd_req_t  req,
  output cbpd_pkg::pd_rsp_t  rsp
);

  localparam int CNT_W = $clog2(cbpd_pkg::GAIN_W + 1);

  logic                               busy_r, busy_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [cbpd_pkg::GAIN_W-1:0]        kp_r, kp_nxt, kd_r, kd_nxt;
  logic signed [cbpd_pkg::ACC_W-1:0]  e_r, e_nxt, d_r, d_nxt;
  logic signed [cbpd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic                               done_r, done_nxt;
  logic signed [cbpd_pkg::ACC_W-1:0]  adj;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    kp_nxt   = kp_r;
    kd_nxt   = kd_r;
    e_nxt    = e_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      kp_nxt   = req.kp;
      kd_nxt   = req.kd;
      e_nxt    = cbpd_pkg::ACC_W'(req.err);
      d_nxt    = cbpd_pkg::ACC_W'(req.err) - cbpd_pkg::ACC_W'(req.last);
      acc_nxt  = '0;
    end else if (busy_r) begin
      // one bit of each gain per cycle
      acc_nxt = acc_r + (kp_r[0] ? e_r : '0) + (kd_r[0] ? d_r : '0);
      kp_nxt  = kp_r >> 1;
      kd_nxt  = kd_r >> 1;
      e_nxt   = e_r <<< 1;
      d_nxt   = d_r <<< 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(cbpd_pkg::GAIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    kp_r  <= kp_nxt;
    kd_r  <= kd_nxt;
    e_r   <= e_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
  end

  // truncate toward zero
  assign adj = acc_r + ((acc_r < 0) ? cbpd_pkg::ACC_W'(255) : '0);
  assign rsp.done   = done_r;
  assign rsp.result = adj >>> 8;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("pd start while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("pd done without run");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> !done_r || $past(busy_r)) else $error("pd spurious done");
`endif

endmodule

>>> design/cbpd_seq.sv
// tick sequencer: loop state, cascade order and result register
module cbpd_seq #(
  parameter int SPEED_LIMIT  = cbpd_pkg::SPEED_LIMIT_DEF,
  parameter int MECH_ZERO    = cbpd_pkg::MECH_ZERO_DEF,
  parameter int SPEED_DIVIDE = cbpd_pkg::SPEED_DIVIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cbpd_in_if.sink                           in_ch,
  cbpd_out_if.source                        out_ch,
  input  logic [cbpd_pkg::GAIN_W-1:0]       speed_kp,
  input  logic [cbpd_pkg::GAIN_W-1:0]       speed_kd,
  input  logic [cbpd_pkg::GAIN_W-1:0]       angle_kp,
  input  logic [cbpd_pkg::GAIN_W-1:0]       angle_kd,
  input  logic [cbpd_pkg::GAIN_W-1:0]       rate_kp,
  input  logic [cbpd_pkg::GAIN_W-1:0]       rate_kd,
  input  logic [cbpd_pkg::LIM_W-1:0]        out_limit,
  input  logic [cbpd_pkg::LIM_W-1:0]        fall_thr,
  output cbpd_pkg::pd_req_t                 pd_req,
  input  cbpd_pkg::pd_rsp_t                 pd_rsp
);

  localparam int PH_W = $clog2(SPEED_DIVIDE + 1);
  localparam int W = cbpd_pkg::DATA_W;
  localparam int A = cbpd_pkg::ACC_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SPEED = 6'b000010,
    ST_ANGLE = 6'b000100,
    ST_RATE  = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PH_W-1:0]        phase_r, phase_nxt;
  logic signed [W-1:0]    enc_sum_r, enc_sum_nxt;
  logic signed [W-1:0]    speed_last_r, speed_last_nxt;
  logic signed [W-1:0]    speed_out_r, speed_out_nxt;
  logic signed [W-1:0]    angle_smp_r, angle_smp_nxt;
  logic signed [W-1:0]    angle_last_r, angle_last_nxt;
  logic signed [W-1:0]    angle_out_r, angle_out_nxt;
  logic signed [W-1:0]    rate_last_r, rate_last_nxt;
  logic signed [W-1:0]    tilt_r, tilt_nxt, gyro_r, gyro_nxt;
  logic                   rest_r, rest_nxt;
  logic [1:0]             pend_r, pend_nxt;
  logic signed [W-1:0]    err_r, err_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [cbpd_pkg::LIM_W-1:0] mag_r, mag_nxt;
  logic                   dir_r, dir_nxt, fall_r, fall_nxt;
  cbpd_pkg::pd_req_t      req_nxt, req_r;

  logic signed [A-1:0]    rate_err_w, rate_u, spd_err_w;
  logic                   fell;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_SPEED = 2'd1;
  localparam logic [1:0] PEND_ANGLE = 2'd2;
  localparam logic [1:0] PEND_RATE  = 2'd3;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = ovalid_r;
  assign out_ch.duty_magnitude = mag_r;
  assign out_ch.direction     = dir_r;
  assign out_ch.fallen        = fall_r;
  assign pd_req               = req_r;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    enc_sum_nxt    = enc_sum_r;
    speed_last_nxt = speed_last_r;
    speed_out_nxt  = speed_out_r;
    angle_smp_nxt  = angle_smp_r;
    angle_last_nxt = angle_last_r;
    angle_out_nxt  = angle_out_r;
    rate_last_nxt  = rate_last_r;
    tilt_nxt       = tilt_r;
    gyro_nxt       = gyro_r;
    rest_nxt       = rest_r;
    pend_nxt       = pend_r;
    err_nxt        = err_r;
    ovalid_nxt     = ovalid_r;
    mag_nxt        = mag_r;
    dir_nxt        = dir_r;
    fall_nxt       = fall_r;
    req_nxt        = '0;
    spd_err_w      = -A'(enc_sum_r);
    rate_err_w     = A'(angle_out_r) + A'(gyro_r);
    rate_u         = cbpd_pkg::clampv(pd_rsp.result, A'(out_limit));
    fell           = (angle_smp_r > $signed({1'b0, fall_thr})) ||
                     (angle_smp_r < -$signed({1'b0, fall_thr})) || rest_r;
    if (out_ch.valid && out_ch.ready) ovalid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          tilt_nxt = in_ch.tilt_angle;
          gyro_nxt = in_ch.gyro_rate;
          rest_nxt = in_ch.rest_request;
          if (phase_r >= PH_W'(SPEED_DIVIDE)) phase_nxt = PH_W'(1);
          else phase_nxt = phase_r + 1'b1;
          enc_sum_nxt = cbpd_pkg::sat16(A'(enc_sum_r) + A'(in_ch.encoder_delta));
          state_nxt = ST_SPEED;
        end
      end
      ST_SPEED: begin
        if (phase_r == PH_W'(SPEED_DIVIDE)) begin
          err_nxt = cbpd_pkg::sat16(spd_err_w);
          enc_sum_nxt = '0;
          req_nxt.start = 1'b1;
          req_nxt.kp = speed_kp;
          req_nxt.kd = speed_kd;
          req_nxt.err = cbpd_pkg::sat16(spd_err_w);
          req_nxt.last = speed_last_r;
          pend_nxt = PEND_SPEED;
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        if (!phase_r[0]) begin
          angle_smp_nxt = cbpd_pkg::sat16(A'(tilt_r) - A'(MECH_ZERO));
          state_nxt = ST_RATE;
          pend_nxt = PEND_ANGLE;
          state_nxt = ST_WAIT;
          req_nxt.start = 1'b1;
        end else begin
          state_nxt = ST_RATE;
        end
      end
      ST_RATE: begin
        err_nxt = cbpd_pkg::sat16(rate_err_w);
        req_nxt.start = 1'b1;
        req_nxt.kp = rate_kp;
        req_nxt.kd = rate_kd;
        req_nxt.err = cbpd_pkg::sat16(rate_err_w);
        req_nxt.last = rate_last_r;
        pend_nxt = PEND_RATE;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (pd_rsp.done) begin
          case (pend_r)
            PEND_SPEED: begin
              speed_out_nxt = W'(cbpd_pkg::clampv(pd_rsp.result, A'(SPEED_LIMIT)));
              speed_last_nxt = err_r;
              state_nxt = ST_ANGLE;
            end
            PEND_ANGLE: begin
              angle_out_nxt = cbpd_pkg::sat16(pd_rsp.result);
              angle_last_nxt = err_r;
              state_nxt = ST_RATE;
            end
            default: begin
              rate_last_nxt = err_r;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        // pd result and sampled angle hold until the next tick starts
        if (!ovalid_r || (out_ch.valid && out_ch.ready)) begin
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
          mag_nxt = '0;
          dir_nxt = 1'b1;
          fall_nxt = fell;
          if (!fell) begin
            dir_nxt = (rate_u >= 0);
            mag_nxt = (rate_u >= 0) ? rate_u[cbpd_pkg::LIM_W-1:0]
                                    : cbpd_pkg::LIM_W'(-rate_u);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // angle request is built after the sample is known
    if (state_r == ST_ANGLE && !phase_r[0]) begin
      err_nxt = cbpd_pkg::sat16(A'(speed_out_r) - A'(angle_smp_nxt));
      req_nxt.kp = angle_kp;
      req_nxt.kd = angle_kd;
      req_nxt.err = err_nxt;
      req_nxt.last = angle_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= '0;
      enc_sum_r    <= '0;
      speed_last_r <= '0;
      speed_out_r  <= '0;
      angle_smp_r  <= '0;
      angle_last_r <= '0;
      angle_out_r  <= '0;
      rate_last_r  <= '0;
      ovalid_r     <= 1'b0;
      pend_r       <= PEND_NONE;
      req_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      enc_sum_r    <= enc_sum_nxt;
      speed_last_r <= speed_last_nxt;
      speed_out_r  <= speed_out_nxt;
      angle_smp_r  <= angle_smp_nxt;
      angle_last_r <= angle_last_nxt;
      angle_out_r  <= angle_out_nxt;
      rate_last_r  <= rate_last_nxt;
      ovalid_r     <= ovalid_nxt;
      pend_r       <= pend_nxt;
      req_r        <= req_nxt;
    end
    tilt_r <= tilt_nxt;
    gyro_r <= gyro_nxt;
    rest_r <= rest_nxt;
    err_r  <= err_nxt;
    mag_r  <= mag_nxt;
    dir_r  <= dir_nxt;
    fall_r <= fall_nxt;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_W'(SPEED_DIVIDE)) else $error("phase out of range");
  a_fall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.fallen) |-> (out_ch.duty_magnitude == '0 && out_ch.direction))
    else $error("fallen result carries duty");
  a_enc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPEED && phase_r == PH_W'(SPEED_DIVIDE)) |=> enc_sum_r == '0)
    else $error("encoder sum not cleared");
`endif

endmodule

>>> design/cascaded_balance_pd_controller_core.sv
// top level of the cascaded balance pd controller
//  channel | direction | contents
//  in_     | sink      | tilt_angle, encoder_delta, gyro_rate, rest_request
//  out_    | source    | duty_magnitude, direction, fallen
//  cfg_    | write     | cfg_we, cfg_index, cfg_data
// a tick runs one, two or three pd loops by phase, each on the one bit-serial
// multiply unit, with handoff steps between them; reset is synchronous and clears
// loop state but not latched inputs, error or outputs; gains to 0, limits to defaults
// a held result stalls the next tick at its output step only
module cascaded_balance_pd_controller_core #(
  parameter int SPEED_LIMIT  = cbpd_pkg::SPEED_LIMIT_DEF,
  parameter int MECH_ZERO    = cbpd_pkg::MECH_ZERO_DEF,
  parameter int SPEED_DIVIDE = cbpd_pkg::SPEED_DIVIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  cbpd_in_if.sink                            in_ch,
  cbpd_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [cbpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbpd_pkg::GAIN_W-1:0]        cfg_data
);

  logic [cbpd_pkg::GAIN_W-1:0] gain_r [6];
  logic [cbpd_pkg::LIM_W-1:0]  out_limit_r, fall_thr_r;
  cbpd_pkg::pd_req_t           pd_req;
  cbpd_pkg::pd_rsp_t           pd_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) gain_r[i] <= '0;
      out_limit_r  <= cbpd_pkg::LIM_W'(5000);
      fall_thr_r   <= cbpd_pkg::LIM_W'(1000);
    end else if (cfg_we) begin
      unique case (cbpd_pkg::cfg_idx_t'(cfg_index))
        cbpd_pkg::REG_SPEED_KP:  gain_r[0] <= cfg_data;
        cbpd_pkg::REG_SPEED_KD:  gain_r[1] <= cfg_data;
        cbpd_pkg::REG_ANGLE_KP:  gain_r[2] <= cfg_data;
        cbpd_pkg::REG_ANGLE_KD:  gain_r[3] <= cfg_data;
        cbpd_pkg::REG_RATE_KP:   gain_r[4] <= cfg_data;
        cbpd_pkg::REG_RATE_KD:   gain_r[5] <= cfg_data;
        cbpd_pkg::REG_OUT_LIMIT: out_limit_r <= cfg_data[cbpd_pkg::LIM_W-1:0];
        cbpd_pkg::REG_FALL:      fall_thr_r <= cfg_data[cbpd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  cbpd_seq #(
    .SPEED_LIMIT(SPEED_LIMIT), .MECH_ZERO(MECH_ZERO), .SPEED_DIVIDE(SPEED_DIVIDE)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .speed_kp(gain_r[0]), .speed_kd(gain_r[1]),
    .angle_kp(gain_r[2]), .angle_kd(gain_r[3]),
    .rate_kp(gain_r[4]), .rate_kd(gain_r[5]),
    .out_limit(out_limit_r), .fall_thr(fall_thr_r),
    .pd_req(pd_req), .pd_rsp(pd_rsp)
  );

  cbpd_pd_serial u_pd (.clk(clk), .rst_n(rst_n), .req(pd_req), .rsp(pd_rsp));

endmodule
